// File: sv/sdrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdrb_pkg
// Shared types and constants of the surround downmix frame ring.
// ----------------------------------------------------------------------------
package sdrb_pkg;

    localparam int RING_FRAMES   = 8192;
    localparam int BLOCK_FRAMES  = 256;
    localparam int SAMPLE_BITS   = 24;

    localparam int GAIN_BITS     = 16;
    localparam int FRAC_BITS     = 15;
    localparam int FILL_OUT_BITS = 14;
    localparam int CMD_DEPTH     = 4;

    localparam int IDX_SPAN      = 2 * RING_FRAMES;
    localparam int IDX_BITS      = $clog2(IDX_SPAN);
    localparam int ADDR_BITS     = $clog2(RING_FRAMES);
    localparam int FILL_BITS     = $clog2(RING_FRAMES + 1);
    localparam int CNT_BITS      = $clog2(BLOCK_FRAMES + 1);
    localparam int NEED_BITS     = $clog2(RING_FRAMES + BLOCK_FRAMES + 1);

    // configuration port
    localparam int PADDR_BITS    = 4;
    localparam int REG_IDX_BITS  = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_ENABLE        = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTER_GAIN   = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SURROUND_GAIN = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_LFE_GAIN      = 2'd3;

    localparam logic [GAIN_BITS-1:0] CENTER_GAIN_RST   = 16'd23170;
    localparam logic [GAIN_BITS-1:0] SURROUND_GAIN_RST = 16'd23170;
    localparam logic [GAIN_BITS-1:0] LFE_GAIN_RST      = 16'd16384;

    // item op codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef struct packed {
        logic                          op;
        logic                          block_start;
        logic signed [SAMPLE_BITS-1:0] front_left;
        logic signed [SAMPLE_BITS-1:0] front_right;
        logic signed [SAMPLE_BITS-1:0] center;
        logic signed [SAMPLE_BITS-1:0] low_freq;
        logic signed [SAMPLE_BITS-1:0] back_left;
        logic signed [SAMPLE_BITS-1:0] back_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          from_buffer;
        logic                          token_release;
        logic                          overrun;
        logic [FILL_OUT_BITS-1:0]      fill_frames;
    } out_item_t;

    typedef struct packed {
        logic                 enable;
        logic [GAIN_BITS-1:0] center_gain;
        logic [GAIN_BITS-1:0] surround_gain;
        logic [GAIN_BITS-1:0] lfe_gain;
    } cfg_t;

    // one classified and mixed item on its way to the ring side
    typedef struct packed {
        logic                          op;
        logic                          block_start;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } cmd_t;

endpackage
`default_nettype wire

// File: sv/sdrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdrb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/sdrb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdrb_front
// Accepts push and pull items, multiplies the gained channels and mixes each
// item to stereo before handing it to the command queue.
// ----------------------------------------------------------------------------
module sdrb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdrb_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sdrb_pkg::in_item_t in_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output sdrb_pkg::cmd_t          q_data
);

    localparam int SB     = sdrb_pkg::SAMPLE_BITS;
    localparam int PROD_W = SB + sdrb_pkg::GAIN_BITS + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] MIX_ROUND =
        ACC_W'(64'sd1 <<< (sdrb_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [SB-1:0] mix_side(
        input logic signed [SB-1:0]     front,
        input logic signed [PROD_W-1:0] p0,
        input logic signed [PROD_W-1:0] p1,
        input logic signed [PROD_W-1:0] p2
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] q;
        acc = (ACC_W'(front) <<< sdrb_pkg::FRAC_BITS) + ACC_W'(p0) + ACC_W'(p1)
            + ACC_W'(p2) + MIX_ROUND;
        // arithmetic shift is a floor, so the bias gives round half up
        q = acc >>> sdrb_pkg::FRAC_BITS;
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return q[SB-1:0];
    endfunction

    logic               s1_valid_reg, s1_valid_next;
    sdrb_pkg::in_item_t s1_item_reg, s1_item_next;

    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_op_reg, s2_op_next;
    logic                     s2_bs_reg, s2_bs_next;
    logic signed [SB-1:0]     s2_fl_reg, s2_fl_next;
    logic signed [SB-1:0]     s2_fr_reg, s2_fr_next;
    logic signed [PROD_W-1:0] s2_c_prod_reg, s2_c_prod_next;
    logic signed [PROD_W-1:0] s2_lfe_prod_reg, s2_lfe_prod_next;
    logic signed [PROD_W-1:0] s2_bl_prod_reg, s2_bl_prod_next;
    logic signed [PROD_W-1:0] s2_br_prod_reg, s2_br_prod_next;

    logic s2_en;
    logic s1_en;

    assign s2_en    = !s2_valid_reg || !q_full;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        s1_item_next     = s1_item_reg;
        s2_valid_next    = s2_valid_reg;
        s2_op_next       = s2_op_reg;
        s2_bs_next       = s2_bs_reg;
        s2_fl_next       = s2_fl_reg;
        s2_fr_next       = s2_fr_reg;
        s2_c_prod_next   = s2_c_prod_reg;
        s2_lfe_prod_next = s2_lfe_prod_reg;
        s2_bl_prod_next  = s2_bl_prod_reg;
        s2_br_prod_next  = s2_br_prod_reg;

        if (s1_en)
        begin
            s1_valid_next = in_valid;
            s1_item_next  = in_data;
        end

        if (s2_en)
        begin
            s2_valid_next    = s1_valid_reg;
            s2_op_next       = s1_item_reg.op;
            s2_bs_next       = s1_item_reg.block_start;
            s2_fl_next       = s1_item_reg.front_left;
            s2_fr_next       = s1_item_reg.front_right;
            s2_c_prod_next   = $signed(s1_item_reg.center)
                             * $signed({1'b0, cfg.center_gain});
            s2_lfe_prod_next = $signed(s1_item_reg.low_freq)
                             * $signed({1'b0, cfg.lfe_gain});
            s2_bl_prod_next  = $signed(s1_item_reg.back_left)
                             * $signed({1'b0, cfg.surround_gain});
            s2_br_prod_next  = $signed(s1_item_reg.back_right)
                             * $signed({1'b0, cfg.surround_gain});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg     <= s1_item_next;
        s2_op_reg       <= s2_op_next;
        s2_bs_reg       <= s2_bs_next;
        s2_fl_reg       <= s2_fl_next;
        s2_fr_reg       <= s2_fr_next;
        s2_c_prod_reg   <= s2_c_prod_next;
        s2_lfe_prod_reg <= s2_lfe_prod_next;
        s2_bl_prod_reg  <= s2_bl_prod_next;
        s2_br_prod_reg  <= s2_br_prod_next;
    end

    assign q_push = s2_valid_reg && !q_full;

    always_comb
    begin
        q_data.op          = s2_op_reg;
        q_data.block_start = s2_bs_reg;
        q_data.left        = mix_side(s2_fl_reg, s2_c_prod_reg, s2_bl_prod_reg,
                                      s2_lfe_prod_reg);
        q_data.right       = mix_side(s2_fr_reg, s2_c_prod_reg, s2_br_prod_reg,
                                      s2_lfe_prod_reg);
    end

endmodule
`default_nettype wire

// File: sv/sdrb_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdrb_cmd_fifo
// Short command queue between the mixing front and the ring back end.
// ----------------------------------------------------------------------------
module sdrb_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sdrb_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                pop_valid,
    output sdrb_pkg::cmd_t      pop_data
);

    localparam int DEPTH  = sdrb_pkg::CMD_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sdrb_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rptr_reg];

endmodule
`default_nettype wire

// File: sv/sdrb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdrb_back
// Ring back end: keeps the read and write indices, stores pushed frames,
// handles block overflow, serves pulls and counts consumed frames.
// ----------------------------------------------------------------------------
module sdrb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           enable,
    input  wire logic           cmd_valid,
    input  wire sdrb_pkg::cmd_t cmd_data,
    output logic                cmd_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sdrb_pkg::out_item_t out_data
);

    localparam int SB     = sdrb_pkg::SAMPLE_BITS;
    localparam int IDX_W  = sdrb_pkg::IDX_BITS;
    localparam int ADDR_W = sdrb_pkg::ADDR_BITS;
    localparam int FILL_W = sdrb_pkg::FILL_BITS;
    localparam int CNT_W  = sdrb_pkg::CNT_BITS;
    localparam int NEED_W = sdrb_pkg::NEED_BITS;
    localparam int FOUT_W = sdrb_pkg::FILL_OUT_BITS;

    localparam logic [IDX_W:0]    SPAN_W    = (IDX_W + 1)'(sdrb_pkg::IDX_SPAN);
    localparam logic [IDX_W-1:0]  RING_IDX  = IDX_W'(sdrb_pkg::RING_FRAMES);
    localparam logic [FILL_W-1:0] RING_FILL = FILL_W'(sdrb_pkg::RING_FRAMES);
    localparam logic [NEED_W-1:0] RING_NEED = NEED_W'(sdrb_pkg::RING_FRAMES);
    localparam logic [NEED_W-1:0] BLK_NEED  = NEED_W'(sdrb_pkg::BLOCK_FRAMES);
    localparam logic [CNT_W-1:0]  BLK_CNT   = CNT_W'(sdrb_pkg::BLOCK_FRAMES);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    function automatic logic [IDX_W-1:0] idx_add(
        input logic [IDX_W-1:0]  idx,
        input logic [FILL_W-1:0] k
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, idx} + (IDX_W + 1)'(k);
        if (sum >= SPAN_W)
        begin
            sum = sum - SPAN_W;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] fill_of(
        input logic [IDX_W-1:0] w,
        input logic [IDX_W-1:0] r
    );
        logic [IDX_W:0] d;
        if (w >= r)
        begin
            d = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            d = {1'b0, w} + SPAN_W - {1'b0, r};
        end
        return FILL_W'(d);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] s;
        s = (idx >= RING_IDX) ? idx - RING_IDX : idx;
        return s[ADDR_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    sdrb_pkg::out_item_t out_data_reg, out_data_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [2*SB-1:0]     ram_wdata;
    logic [2*SB-1:0]     ram_rdata;

    // push bookkeeping
    logic [FILL_W-1:0] fill0;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] excess;
    logic              blk_ovf;
    logic [FILL_W-1:0] drop;
    logic [IDX_W-1:0]  rd_idx1;
    logic [FILL_W-1:0] fill1;
    logic              ring_full;
    logic [IDX_W-1:0]  rd_idx2;
    logic [FILL_W-1:0] fill_after;
    // pull bookkeeping
    logic [CNT_W-1:0]  cnt_inc;
    logic              token;

    always_comb
    begin
        fill0      = fill_of(wr_idx_reg, rd_idx_reg);
        need       = NEED_W'(fill0) + BLK_NEED;
        excess     = need - RING_NEED;
        blk_ovf    = cmd_data.block_start && (need > RING_NEED);
        drop       = (excess > NEED_W'(fill0)) ? fill0 : FILL_W'(excess);
        rd_idx1    = blk_ovf ? idx_add(rd_idx_reg, drop) : rd_idx_reg;
        fill1      = blk_ovf ? fill0 - drop : fill0;
        ring_full  = (fill1 >= RING_FILL);
        rd_idx2    = ring_full ? idx_add(rd_idx1, FILL_W'(1)) : rd_idx1;
        fill_after = ring_full ? fill1 : fill1 + FILL_W'(1);
        cnt_inc    = cnt_reg + CNT_W'(1);
        token      = (cnt_inc >= BLK_CNT);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        cnt_next       = cnt_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = slot_of(wr_idx_reg);
        ram_raddr      = slot_of(rd_idx_reg);
        ram_wdata      = {cmd_data.left, cmd_data.right};

        case (state_reg)
            ST_IDLE:
            begin
                if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (cmd_valid && (!out_valid_reg || out_ready))
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (cmd_data.op == sdrb_pkg::OP_PULL)
                    begin
                        out_data_next.fill_frames = FOUT_W'(fill0);
                        if (fill0 != '0)
                        begin
                            // samples land in the next cycle from the registered RAM read port
                            ram_re                      = 1'b1;
                            rd_idx_next                 = idx_add(rd_idx_reg,
                                                                  FILL_W'(1));
                            cnt_next                    = token ? '0 : cnt_inc;
                            out_data_next.from_buffer   = 1'b1;
                            out_data_next.token_release = token;
                            out_data_next.fill_frames   = FOUT_W'(fill0 - FILL_W'(1));
                            out_valid_next              = 1'b0;
                            state_next                  = ST_READ;
                        end
                    end
                    else if (enable)
                    begin
                        ram_we                    = 1'b1;
                        wr_idx_next               = idx_add(wr_idx_reg, FILL_W'(1));
                        rd_idx_next               = rd_idx2;
                        out_data_next.overrun     = blk_ovf || ring_full;
                        out_data_next.fill_frames = FOUT_W'(fill_after);
                    end
                    else
                    begin
                        out_data_next.fill_frames = FOUT_W'(fill0);
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next          = 1'b1;
                out_data_next.left_out  = ram_rdata[2*SB-1:SB];
                out_data_next.right_out = ram_rdata[SB-1:0];
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    sdrb_ram #(
        .WIDTH (2 * SB),
        .DEPTH (sdrb_pkg::RING_FRAMES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_read_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !out_valid_reg)
        else $error("result register busy while ring read is pending");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill0 <= RING_FILL)
        else $error("ring fill beyond capacity");

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (!out_valid_reg || out_ready))
        else $error("command taken while result register is held");

    a_token_from_ring: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.token_release |-> out_data_reg.from_buffer)
        else $error("token without a frame from the ring");

    a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> state_reg == ST_READ ##1 out_valid_reg)
        else $error("ring read did not produce a result");
`endif

endmodule
`default_nettype wire

// File: sv/surround_downmix_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// surround_downmix_ring_buffer
// 5.1 to stereo downmix feeding a frame ring, with overflow drop and
// consumed-frame token pulses.
//
//   channel  signals                              transfer when
//   cfg      psel penable pwrite paddr pwdata     psel & penable & pwrite
//   in       in_valid in_ready in_data            in_valid & in_ready
//   out      out_valid out_ready out_data         out_valid & out_ready
//
// Push and pull results pass the mixing stages, the command queue and the
// result register, a pull also the ring RAM read. The back end retires one push
// per cycle while the output is not held; a pull holds off new commands in ST_READ.
// Up to 6 items can sit in the mixing stages and queue behind a stalled output.
// Reset clears indices, counters and registers; ring contents need no clearing.
// ----------------------------------------------------------------------------
module surround_downmix_ring_buffer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sdrb_pkg::PADDR_BITS-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire sdrb_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output sdrb_pkg::out_item_t                      out_data
);

    localparam int GW = sdrb_pkg::GAIN_BITS;

    logic          enable_reg, enable_next;
    logic [GW-1:0] center_gain_reg, center_gain_next;
    logic [GW-1:0] surround_gain_reg, surround_gain_next;
    logic [GW-1:0] lfe_gain_reg, lfe_gain_next;

    logic                                cfg_wr;
    logic [sdrb_pkg::REG_IDX_BITS-1:0]   reg_idx;
    sdrb_pkg::cfg_t                      cfg;

    logic           q_full;
    logic           q_push;
    sdrb_pkg::cmd_t q_wdata;
    logic           q_pop;
    logic           q_valid;
    sdrb_pkg::cmd_t q_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[sdrb_pkg::PADDR_BITS-1:2];

    always_comb
    begin
        enable_next        = enable_reg;
        center_gain_next   = center_gain_reg;
        surround_gain_next = surround_gain_reg;
        lfe_gain_next      = lfe_gain_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                sdrb_pkg::REG_ENABLE:        enable_next        = pwdata[0];
                sdrb_pkg::REG_CENTER_GAIN:   center_gain_next   = pwdata[GW-1:0];
                sdrb_pkg::REG_SURROUND_GAIN: surround_gain_next = pwdata[GW-1:0];
                sdrb_pkg::REG_LFE_GAIN:      lfe_gain_next      = pwdata[GW-1:0];
                default:                     enable_next        = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            center_gain_reg   <= sdrb_pkg::CENTER_GAIN_RST;
            surround_gain_reg <= sdrb_pkg::SURROUND_GAIN_RST;
            lfe_gain_reg      <= sdrb_pkg::LFE_GAIN_RST;
        end
        else
        begin
            enable_reg        <= enable_next;
            center_gain_reg   <= center_gain_next;
            surround_gain_reg <= surround_gain_next;
            lfe_gain_reg      <= lfe_gain_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            sdrb_pkg::REG_ENABLE:        prdata = {31'b0, enable_reg};
            sdrb_pkg::REG_CENTER_GAIN:   prdata = {16'b0, center_gain_reg};
            sdrb_pkg::REG_SURROUND_GAIN: prdata = {16'b0, surround_gain_reg};
            sdrb_pkg::REG_LFE_GAIN:      prdata = {16'b0, lfe_gain_reg};
            default:                     prdata = '0;
        endcase
    end

    assign cfg.enable        = enable_reg;
    assign cfg.center_gain   = center_gain_reg;
    assign cfg.surround_gain = surround_gain_reg;
    assign cfg.lfe_gain      = lfe_gain_reg;

    sdrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    sdrb_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rdata)
    );

    sdrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .cmd_valid (q_valid),
        .cmd_data  (q_rdata),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the surround downmix frame ring. A scoreboard class
// mixes each enabled 5.1 push into its own copy of the stereo ring, tracks
// the read/write indices and token counter, and checks every result transfer
// in order. Directed corner frames come first, then randomized block-shaped
// traffic under several gain settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SB  = sdrb_pkg::SAMPLE_BITS;
    localparam int GB  = sdrb_pkg::GAIN_BITS;
    localparam int FOB = sdrb_pkg::FILL_OUT_BITS;

    class downmix_scoreboard;
        sdrb_pkg::cfg_t        cfg;
        logic signed [SB-1:0]  ring_left  [sdrb_pkg::RING_FRAMES];
        logic signed [SB-1:0]  ring_right [sdrb_pkg::RING_FRAMES];
        int unsigned           wr_idx;
        int unsigned           rd_idx;
        int unsigned           consumed;
        sdrb_pkg::out_item_t   expected_frames[$];
        int                    errors;

        function new();
            cfg.enable        = 1'b0;
            cfg.center_gain   = sdrb_pkg::CENTER_GAIN_RST;
            cfg.surround_gain = sdrb_pkg::SURROUND_GAIN_RST;
            cfg.lfe_gain      = sdrb_pkg::LFE_GAIN_RST;
            wr_idx   = 0;
            rd_idx   = 0;
            consumed = 0;
            errors   = 0;
        endfunction

        function int unsigned fill_now();
            return (wr_idx + sdrb_pkg::IDX_SPAN - rd_idx) % sdrb_pkg::IDX_SPAN;
        endfunction

        // round half up by dropping the fraction bits, then saturate
        function logic signed [SB-1:0] mix_side(input longint front,
                                                input longint ctr,
                                                input longint back,
                                                input longint lfe);
            longint acc;
            longint q;
            longint hi;
            longint lo;
            hi  = (longint'(1) <<< (SB - 1)) - 1;
            lo  = -hi - 1;
            acc = front * 32768 + ctr * longint'(cfg.center_gain)
                + back * longint'(cfg.surround_gain)
                + lfe * longint'(cfg.lfe_gain) + 16384;
            q = acc >>> sdrb_pkg::FRAC_BITS;
            if (q > hi)
            begin
                q = hi;
            end
            if (q < lo)
            begin
                q = lo;
            end
            return q[SB-1:0];
        endfunction

        function void apply_item(input sdrb_pkg::in_item_t item);
            sdrb_pkg::out_item_t res;
            int unsigned         fill;
            int unsigned         drop;
            int unsigned         slot;
            res = '0;
            if (item.op == sdrb_pkg::OP_PUSH)
            begin
                if (cfg.enable)
                begin
                    fill = fill_now();
                    if (item.block_start
                        && (fill + sdrb_pkg::BLOCK_FRAMES > sdrb_pkg::RING_FRAMES))
                    begin
                        drop = fill + sdrb_pkg::BLOCK_FRAMES - sdrb_pkg::RING_FRAMES;
                        if (drop > fill)
                        begin
                            drop = fill;
                        end
                        rd_idx      = (rd_idx + drop) % sdrb_pkg::IDX_SPAN;
                        res.overrun = 1'b1;
                        fill        = fill_now();
                    end
                    if (fill >= sdrb_pkg::RING_FRAMES)
                    begin
                        rd_idx      = (rd_idx + 1) % sdrb_pkg::IDX_SPAN;
                        res.overrun = 1'b1;
                    end
                    slot = wr_idx % sdrb_pkg::RING_FRAMES;
                    ring_left[slot]  = mix_side(longint'(item.front_left),
                                                longint'(item.center),
                                                longint'(item.back_left),
                                                longint'(item.low_freq));
                    ring_right[slot] = mix_side(longint'(item.front_right),
                                                longint'(item.center),
                                                longint'(item.back_right),
                                                longint'(item.low_freq));
                    wr_idx = (wr_idx + 1) % sdrb_pkg::IDX_SPAN;
                end
            end
            else if (fill_now() > 0)
            begin
                slot            = rd_idx % sdrb_pkg::RING_FRAMES;
                res.left_out    = ring_left[slot];
                res.right_out   = ring_right[slot];
                res.from_buffer = 1'b1;
                rd_idx          = (rd_idx + 1) % sdrb_pkg::IDX_SPAN;
                consumed++;
                if (consumed >= sdrb_pkg::BLOCK_FRAMES)
                begin
                    consumed          = 0;
                    res.token_release = 1'b1;
                end
            end
            res.fill_frames = FOB'(fill_now());
            expected_frames.push_back(res);
        endfunction

        function void check_result(input sdrb_pkg::out_item_t got);
            sdrb_pkg::out_item_t want;
            bit                  bad;
            if (expected_frames.size() == 0)
            begin
                errors++;
                $error("result with nothing pending: %p", got);
                return;
            end
            want = expected_frames.pop_front();
            bad  = (got !== want);
            if (bad)
            begin
                errors++;
                if (got.left_out !== want.left_out)
                begin
                    $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
                end
                if (got.right_out !== want.right_out)
                begin
                    $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
                end
                if (got.from_buffer !== want.from_buffer)
                begin
                    $error("from_buffer: expected %0d, got %0d",
                           want.from_buffer, got.from_buffer);
                end
                if (got.token_release !== want.token_release)
                begin
                    $error("token_release: expected %0d, got %0d",
                           want.token_release, got.token_release);
                end
                if (got.overrun !== want.overrun)
                begin
                    $error("overrun: expected %0d, got %0d", want.overrun, got.overrun);
                end
                if (got.fill_frames !== want.fill_frames)
                begin
                    $error("fill_frames: expected %0d, got %0d",
                           want.fill_frames, got.fill_frames);
                end
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [sdrb_pkg::PADDR_BITS-1:0]    paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_ready;
    sdrb_pkg::in_item_t                 in_data;
    logic                               out_valid;
    logic                               out_ready;
    sdrb_pkg::out_item_t                out_data;

    downmix_scoreboard      sb;
    int                     src_idle_pct;
    int                     sink_idle_pct;
    int                     hold_left;
    int unsigned            block_pos;

    surround_downmix_ring_buffer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic logic signed [SB-1:0] smp(input int v);
        return SB'(v);
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic sdrb_pkg::in_item_t push_frame(input logic bs,
                                                      input logic signed [SB-1:0] fl,
                                                      input logic signed [SB-1:0] fr,
                                                      input logic signed [SB-1:0] c,
                                                      input logic signed [SB-1:0] lf,
                                                      input logic signed [SB-1:0] bl,
                                                      input logic signed [SB-1:0] br);
        sdrb_pkg::in_item_t item;
        item.op          = sdrb_pkg::OP_PUSH;
        item.block_start = bs;
        item.front_left  = fl;
        item.front_right = fr;
        item.center      = c;
        item.low_freq    = lf;
        item.back_left   = bl;
        item.back_right  = br;
        return item;
    endfunction

    function automatic sdrb_pkg::in_item_t rand_frame(input logic op, input logic bs);
        sdrb_pkg::in_item_t item;
        item    = push_frame(bs, rand_sample(), rand_sample(), rand_sample(),
                             rand_sample(), rand_sample(), rand_sample());
        item.op = op;
        return item;
    endfunction

    // pushes follow 256-frame block framing, with an occasional misplaced start
    function automatic sdrb_pkg::in_item_t next_random_item();
        logic bs;
        if ($urandom_range(0, 99) < 52)
        begin
            bs = (block_pos == 0);
            if ($urandom_range(0, 19) == 0)
            begin
                bs = ~bs;
            end
            block_pos = (block_pos + 1) % sdrb_pkg::BLOCK_FRAMES;
            return rand_frame(sdrb_pkg::OP_PUSH, bs);
        end
        return rand_frame(sdrb_pkg::OP_PULL, 1'($urandom));
    endfunction

    task automatic send_item(input sdrb_pkg::in_item_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do @(posedge clk); while (!in_ready);
        sb.apply_item(item);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sdrb_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [GB-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            sdrb_pkg::REG_ENABLE:        sb.cfg.enable        = pwdata[0];
            sdrb_pkg::REG_CENTER_GAIN:   sb.cfg.center_gain   = pwdata[GB-1:0];
            sdrb_pkg::REG_SURROUND_GAIN: sb.cfg.surround_gain = pwdata[GB-1:0];
            sdrb_pkg::REG_LFE_GAIN:      sb.cfg.lfe_gain      = pwdata[GB-1:0];
            default:                     ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [GB-1:0] cg,
                              input logic [GB-1:0] sg,
                              input logic [GB-1:0] lg);
        wait_idle();
        write_reg(sdrb_pkg::REG_ENABLE, {15'd0, en});
        write_reg(sdrb_pkg::REG_CENTER_GAIN, cg);
        write_reg(sdrb_pkg::REG_SURROUND_GAIN, sg);
        write_reg(sdrb_pkg::REG_LFE_GAIN, lg);
    endtask

    // sink side: random back-pressure plus requested long hold-offs
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_data);
        end
    end

    initial
    begin
        #2_000_000;
        $display("surround_downmix_ring_buffer verification failed");
        $finish;
    end

    initial
    begin
        logic signed [SB-1:0] pos_max;
        logic signed [SB-1:0] neg_max;
        int                   chunk;
        int                   i;

        pos_max       = {1'b0, {(SB-1){1'b1}}};
        neg_max       = {1'b1, {(SB-1){1'b0}}};
        sb            = new();
        src_idle_pct  = 24;
        sink_idle_pct = 55;
        hold_left     = 0;
        block_pos     = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled push is dropped; pull on an empty ring returns zeros
        send_item(rand_frame(sdrb_pkg::OP_PUSH, 1'b1));
        send_item(rand_frame(sdrb_pkg::OP_PULL, 1'b0));

        set_config(1'b1, sdrb_pkg::CENTER_GAIN_RST, sdrb_pkg::SURROUND_GAIN_RST,
                   sdrb_pkg::LFE_GAIN_RST);
        send_item(push_frame(1'b1, pos_max, pos_max, pos_max, pos_max, pos_max, pos_max));
        send_item(push_frame(1'b0, neg_max, neg_max, neg_max, neg_max, neg_max, neg_max));
        send_item(push_frame(1'b0, smp(0), smp(0), smp(0), smp(0), smp(0), smp(0)));
        // exact half LSB, positive and negative: rounds toward plus infinity
        send_item(push_frame(1'b0, smp(0), smp(0), smp(0), smp(1), smp(0), smp(0)));
        send_item(push_frame(1'b0, smp(0), smp(0), smp(0), smp(-1), smp(0), smp(0)));
        send_item(push_frame(1'b0, pos_max, neg_max, smp(-1), smp(1), neg_max, pos_max));
        send_item(push_frame(1'b1, smp(1), smp(-1), smp(4095), smp(-4096), smp(123456),
                             smp(-654321)));

        // pulls still drain while disabled
        set_config(1'b0, sdrb_pkg::CENTER_GAIN_RST, sdrb_pkg::SURROUND_GAIN_RST,
                   sdrb_pkg::LFE_GAIN_RST);
        send_item(rand_frame(sdrb_pkg::OP_PUSH, 1'b0));
        send_item(rand_frame(sdrb_pkg::OP_PULL, 1'b0));
        send_item(rand_frame(sdrb_pkg::OP_PULL, 1'b1));

        // gains near 2.0
        set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(push_frame(1'b0, pos_max, neg_max, pos_max, pos_max, neg_max, pos_max));
        send_item(push_frame(1'b0, smp(1000), smp(-1000), smp(-3), smp(7), smp(1),
                             smp(-1)));
        for (i = 0; i < 8; i++)
        begin
            send_item(rand_frame(sdrb_pkg::OP_PULL, 1'b0));
        end

        for (chunk = 0; chunk < 6; chunk++)
        begin
            case (chunk)
                0: set_config(1'b1, sdrb_pkg::CENTER_GAIN_RST, sdrb_pkg::SURROUND_GAIN_RST,
                              sdrb_pkg::LFE_GAIN_RST);
                1: set_config(1'b1, 16'd0, 16'd0, 16'd0);
                2: set_config(1'b1, 16'd32768, 16'd32768, 16'd32768);
                3: set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: set_config(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
                default: set_config(1'b1, 16'($urandom_range(0, 32768)),
                                    16'($urandom_range(0, 32768)),
                                    16'($urandom_range(0, 32768)));
            endcase
            if (chunk < 2)
            begin
                src_idle_pct  = 24;
                sink_idle_pct = 55;
            end
            else if (chunk < 4)
            begin
                src_idle_pct  = 55;
                sink_idle_pct = 24;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (chunk == 0)
            begin
                hold_left = 400;
            end
            for (i = 0; i < 175; i++)
            begin
                send_item(next_random_item());
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("surround_downmix_ring_buffer verification clean");
        end
        else
        begin
            $display("surround_downmix_ring_buffer verification failed");
        end
        $finish;
    end

endmodule

// File: surround_downmix_ring_buffer.f
sv/sdrb_pkg.sv
sv/sdrb_ram.sv
sv/sdrb_front.sv
sv/sdrb_cmd_fifo.sv
sv/sdrb_back.sv
sv/surround_downmix_ring_buffer.sv
sim/testbench.sv
